@@ hw/rtl/fpra_pkg.sv @@
// ----------------------------------------------------------------------------
// fpra_pkg: shared definitions for the first-fit page run allocator
// Sizes, field widths, status and command codes, sequencer states and the
// structs that carry memory requests and results between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fpra_pkg;

    // Sizing of the page bitmap and the allocation table.
    localparam int NUM_PAGES   = 1024;
    localparam int ALLOC_SLOTS = 64;

    localparam int PAGE_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int SLOT_W = (ALLOC_SLOTS > 1) ? $clog2(ALLOC_SLOTS) : 1;

    // Fixed field widths of the ports.
    localparam int FIRST_W     = 10;
    localparam int COUNT_W     = 11;
    localparam int START_W     = 10;
    localparam int RUN_START_W = 10;
    localparam int FREED_W     = 11;

    // Derived internal widths.
    localparam int PTR_W  = PAGE_W + 1;
    localparam int SCNT_W = SLOT_W + 1;
    localparam int IDX_W  = (PAGE_W > START_W) ? PAGE_W : START_W;
    localparam int RUN_W  = (PAGE_W + 2 > COUNT_W) ? PAGE_W + 2 : COUNT_W;
    localparam int TBL_W  = PAGE_W + COUNT_W;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_NO_SPACE   = 2'd1,
        STAT_NOT_FOUND  = 2'd2,
        STAT_TABLE_FULL = 2'd3
    } status_t;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SLOT,
        ST_SCAN,
        ST_MARK,
        ST_LOOK,
        ST_UNMARK,
        ST_DONE
    } state_t;

    // Request to the page bitmap memory.
    typedef struct packed {
        logic              we;
        logic [PAGE_W-1:0] waddr;
        logic              wdata;
        logic [PAGE_W-1:0] raddr;
    } map_req_t;

    // Request to the allocation table memory.
    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [TBL_W-1:0]  wdata;
        logic [SLOT_W-1:0] raddr;
    } tbl_req_t;

    // One finished result.
    typedef struct packed {
        status_t                status;
        logic [RUN_START_W-1:0] run_start;
        logic [FREED_W-1:0]     freed_pages;
    } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/first_fit_page_run_allocator.sv @@
// An allocate finds the lowest free slot, scans the bitmap from first_page and marks the run;
// a free looks up the matching slot and clears its pages. Pages move one per cycle through
// the bitmap memory port. One transaction is in work at a time; the next is taken once
// the result sits in the output register. After reset a clearing pass empties the
// bitmap, during which no transaction is accepted.
// ----------------------------------------------------------------------------
// first_fit_page_run_allocator: first-fit page run allocator, top level
// Configuration register, output register and the bitmap and table memories
// around the allocator sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_page_run_allocator (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_command,
    input  wire logic [fpra_pkg::COUNT_W-1:0]        s_page_count,
    input  wire logic [fpra_pkg::START_W-1:0]        s_start_page,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic      [1:0]                          m_status,
    output logic      [fpra_pkg::RUN_START_W-1:0]    m_run_start,
    output logic      [fpra_pkg::FREED_W-1:0]        m_freed_pages,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [fpra_pkg::FIRST_W-1:0]        cfg_data
);

    logic [fpra_pkg::FIRST_W-1:0]   first_page_reg;
    logic                           m_valid_reg;
    fpra_pkg::result_t              out_reg;
    logic                           item_go;
    logic                           seq_idle;
    logic                           res_valid;
    logic                           result_take;
    fpra_pkg::result_t              result;
    fpra_pkg::map_req_t             map_req;
    fpra_pkg::tbl_req_t             tbl_req;
    logic                           map_rdata;
    logic [fpra_pkg::TBL_W-1:0]     tbl_rdata;

    // Handshakes.
    assign cfg_ready   = 1'b1;
    assign s_ready     = seq_idle;
    assign item_go     = s_valid && seq_idle;
    assign result_take = res_valid && (!m_valid_reg || m_ready);

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_page_reg <= '0;
        end else if (cfg_valid) begin
            first_page_reg <= cfg_data;
        end
    end

    // Output register: frees the sequencer while the result waits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (result_take) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (result_take) begin
            out_reg <= result;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = out_reg.status;
    assign m_run_start   = out_reg.run_start;
    assign m_freed_pages = out_reg.freed_pages;

    // Sequencer.
    fpra_seq u_seq (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .item_go         (item_go),
        .item_command    (s_command),
        .item_page_count (s_page_count),
        .item_start_page (s_start_page),
        .first_page      (first_page_reg),
        .map_rdata       (map_rdata),
        .tbl_rdata       (tbl_rdata),
        .result_take     (result_take),
        .idle            (seq_idle),
        .res_valid       (res_valid),
        .result          (result),
        .map_req         (map_req),
        .tbl_req         (tbl_req)
    );

    // Page mark bitmap.
    fpra_ram #(
        .WIDTH (1),
        .DEPTH (fpra_pkg::NUM_PAGES)
    ) u_map_ram (
        .aclk  (aclk),
        .we    (map_req.we),
        .waddr (map_req.waddr),
        .wdata (map_req.wdata),
        .raddr (map_req.raddr),
        .rdata (map_rdata)
    );

    // Allocation table: start page and page count per slot.
    fpra_ram #(
        .WIDTH (fpra_pkg::TBL_W),
        .DEPTH (fpra_pkg::ALLOC_SLOTS)
    ) u_tbl_ram (
        .aclk  (aclk),
        .we    (tbl_req.we),
        .waddr (tbl_req.waddr),
        .wdata (tbl_req.wdata),
        .raddr (tbl_req.raddr),
        .rdata (tbl_rdata)
    );

`ifndef SYNTHESIS
    // A failed or free result never reports a run start.
    a_fail_no_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != fpra_pkg::STAT_OK || m_freed_pages != '0)
        |-> m_run_start == '0)
        else $error("run start reported on a result without an allocation");

    // Only a successful free reports released pages.
    a_freed_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != fpra_pkg::STAT_OK |-> m_freed_pages == '0)
        else $error("freed pages reported on a failed transaction");

    // A transaction is never accepted right after another one.
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transaction taken while one is in work");

    // The clearing pass keeps the input closed right after reset.
    a_clear_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) == 1'b0 |-> !s_ready)
        else $error("input opened before the bitmap was cleared");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/fpra_ram.sv @@
// ----------------------------------------------------------------------------
// fpra_ram: generic single-clock RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module fpra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      aclk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/fpra_seq.sv @@
// ----------------------------------------------------------------------------
// fpra_seq: allocator sequencer
// Walks the slot valid bits, scans the page bitmap one page per cycle,
// marks and unmarks runs and looks up the allocation table.
// ----------------------------------------------------------------------------
`default_nettype none

module fpra_seq (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            item_go,
    input  wire logic                            item_command,
    input  wire logic [fpra_pkg::COUNT_W-1:0]    item_page_count,
    input  wire logic [fpra_pkg::START_W-1:0]    item_start_page,
    input  wire logic [fpra_pkg::FIRST_W-1:0]    first_page,
    input  wire logic                            map_rdata,
    input  wire logic [fpra_pkg::TBL_W-1:0]      tbl_rdata,
    input  wire logic                            result_take,
    output logic                                 idle,
    output logic                                 res_valid,
    output fpra_pkg::result_t                    result,
    output fpra_pkg::map_req_t                   map_req,
    output fpra_pkg::tbl_req_t                   tbl_req
);

    fpra_pkg::state_t                    state_reg, state_next;
    fpra_pkg::cmd_t                      cmd_reg, cmd_next;
    logic [fpra_pkg::COUNT_W-1:0]        count_reg, count_next;
    logic [fpra_pkg::START_W-1:0]        start_reg, start_next;
    logic [fpra_pkg::PTR_W-1:0]          ptr_reg, ptr_next;
    logic                                chk_vld_reg, chk_vld_next;
    logic [fpra_pkg::PTR_W-1:0]          chk_ptr_reg, chk_ptr_next;
    logic [fpra_pkg::SLOT_W-1:0]         chk_slot_reg, chk_slot_next;
    logic                                chk_valid_reg, chk_valid_next;
    logic [fpra_pkg::RUN_W-1:0]          run_reg, run_next;
    logic [fpra_pkg::PAGE_W-1:0]         base_reg, base_next;
    logic [fpra_pkg::PAGE_W-1:0]         end_reg, end_next;
    logic [fpra_pkg::SCNT_W-1:0]         slot_ptr_reg, slot_ptr_next;
    logic [fpra_pkg::SLOT_W-1:0]         slot_reg, slot_next;
    fpra_pkg::status_t                   status_reg, status_next;
    logic [fpra_pkg::RUN_START_W-1:0]    run_start_reg, run_start_next;
    logic [fpra_pkg::FREED_W-1:0]        freed_reg, freed_next;
    logic [fpra_pkg::ALLOC_SLOTS-1:0]    valid_reg, valid_next;

    logic [fpra_pkg::SLOT_W-1:0]         slot_idx;
    logic                                slot_is_free;
    logic                                slot_last;
    logic                                first_out;
    logic                                issue_page;
    logic                                issue_slot;
    logic [fpra_pkg::RUN_W-1:0]          run_inc;
    logic [fpra_pkg::RUN_W-1:0]          base_calc;
    logic                                scan_fit;
    logic                                scan_last;
    logic                                mark_last;
    logic [fpra_pkg::PAGE_W-1:0]         tbl_start;
    logic [fpra_pkg::COUNT_W-1:0]        tbl_pages;
    logic                                look_hit;
    logic                                look_last;
    logic                                unmark_last;
    logic                                init_last;
    logic                                count_zero;

    // Decision flags shared by the next-state and datapath logic.
    always_comb begin
        slot_idx     = slot_ptr_reg[fpra_pkg::SLOT_W-1:0];
        slot_is_free = !valid_reg[slot_idx];
        slot_last    = (slot_ptr_reg == fpra_pkg::SCNT_W'(fpra_pkg::ALLOC_SLOTS - 1));
        first_out    = ((fpra_pkg::IDX_W + 1)'(first_page)
                        >= (fpra_pkg::IDX_W + 1)'(fpra_pkg::NUM_PAGES));
        issue_page   = (ptr_reg < fpra_pkg::PTR_W'(fpra_pkg::NUM_PAGES));
        issue_slot   = (slot_ptr_reg < fpra_pkg::SCNT_W'(fpra_pkg::ALLOC_SLOTS));
        run_inc      = run_reg + fpra_pkg::RUN_W'(1);
        base_calc    = fpra_pkg::RUN_W'(chk_ptr_reg) + fpra_pkg::RUN_W'(1)
                       - fpra_pkg::RUN_W'(count_reg);
        scan_fit     = chk_vld_reg && !map_rdata
                       && (run_inc == fpra_pkg::RUN_W'(count_reg));
        scan_last    = chk_vld_reg
                       && (chk_ptr_reg == fpra_pkg::PTR_W'(fpra_pkg::NUM_PAGES - 1));
        mark_last    = (ptr_reg[fpra_pkg::PAGE_W-1:0] == end_reg);
        tbl_start    = tbl_rdata[fpra_pkg::TBL_W-1 -: fpra_pkg::PAGE_W];
        tbl_pages    = tbl_rdata[fpra_pkg::COUNT_W-1:0];
        look_hit     = chk_vld_reg && chk_valid_reg
                       && (fpra_pkg::IDX_W'(tbl_start) == fpra_pkg::IDX_W'(start_reg));
        look_last    = chk_vld_reg
                       && (chk_slot_reg == fpra_pkg::SLOT_W'(fpra_pkg::ALLOC_SLOTS - 1));
        unmark_last  = (count_reg == fpra_pkg::COUNT_W'(1));
        init_last    = (ptr_reg == fpra_pkg::PTR_W'(fpra_pkg::NUM_PAGES - 1));
        count_zero   = (item_page_count == '0);
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            fpra_pkg::ST_INIT: begin
                if (init_last) begin
                    state_next = fpra_pkg::ST_IDLE;
                end
            end
            fpra_pkg::ST_IDLE: begin
                if (item_go) begin
                    if (fpra_pkg::cmd_t'(item_command) == fpra_pkg::CMD_FREE) begin
                        state_next = fpra_pkg::ST_LOOK;
                    end else if (count_zero) begin
                        state_next = fpra_pkg::ST_DONE;
                    end else begin
                        state_next = fpra_pkg::ST_SLOT;
                    end
                end
            end
            fpra_pkg::ST_SLOT: begin
                if (slot_is_free) begin
                    state_next = first_out ? fpra_pkg::ST_DONE : fpra_pkg::ST_SCAN;
                end else if (slot_last) begin
                    state_next = fpra_pkg::ST_DONE;
                end
            end
            fpra_pkg::ST_SCAN: begin
                if (scan_fit) begin
                    state_next = fpra_pkg::ST_MARK;
                end else if (scan_last) begin
                    state_next = fpra_pkg::ST_DONE;
                end
            end
            fpra_pkg::ST_MARK: begin
                if (mark_last) begin
                    state_next = fpra_pkg::ST_DONE;
                end
            end
            fpra_pkg::ST_LOOK: begin
                if (look_hit) begin
                    state_next = fpra_pkg::ST_UNMARK;
                end else if (look_last) begin
                    state_next = fpra_pkg::ST_DONE;
                end
            end
            fpra_pkg::ST_UNMARK: begin
                if (unmark_last) begin
                    state_next = fpra_pkg::ST_DONE;
                end
            end
            fpra_pkg::ST_DONE: begin
                if (result_take) begin
                    state_next = fpra_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fpra_pkg::ST_INIT;
            end
        endcase
    end

    // Datapath registers: pointers, run length, slot choice and result.
    always_comb begin
        cmd_next       = cmd_reg;
        count_next     = count_reg;
        start_next     = start_reg;
        ptr_next       = ptr_reg;
        chk_vld_next   = chk_vld_reg;
        chk_ptr_next   = chk_ptr_reg;
        chk_slot_next  = chk_slot_reg;
        chk_valid_next = chk_valid_reg;
        run_next       = run_reg;
        base_next      = base_reg;
        end_next       = end_reg;
        slot_ptr_next  = slot_ptr_reg;
        slot_next      = slot_reg;
        status_next    = status_reg;
        run_start_next = run_start_reg;
        freed_next     = freed_reg;
        valid_next     = valid_reg;
        case (state_reg)
            fpra_pkg::ST_INIT: begin
                ptr_next = ptr_reg + fpra_pkg::PTR_W'(1);
            end
            fpra_pkg::ST_IDLE: begin
                if (item_go) begin
                    cmd_next       = fpra_pkg::cmd_t'(item_command);
                    count_next     = item_page_count;
                    start_next     = item_start_page;
                    slot_ptr_next  = '0;
                    chk_vld_next   = 1'b0;
                    run_start_next = '0;
                    freed_next     = '0;
                    status_next    = fpra_pkg::STAT_NO_SPACE;
                end
            end
            fpra_pkg::ST_SLOT: begin
                if (slot_is_free) begin
                    // Lowest free slot found; start the scan at the first page.
                    slot_next    = slot_idx;
                    ptr_next     = fpra_pkg::PTR_W'(first_page);
                    run_next     = '0;
                    chk_vld_next = 1'b0;
                    status_next  = fpra_pkg::STAT_NO_SPACE;
                end else if (slot_last) begin
                    status_next = fpra_pkg::STAT_TABLE_FULL;
                end else begin
                    slot_ptr_next = slot_ptr_reg + fpra_pkg::SCNT_W'(1);
                end
            end
            fpra_pkg::ST_SCAN: begin
                // Issue one bitmap read per cycle and check the one before.
                chk_vld_next = issue_page;
                chk_ptr_next = ptr_reg;
                if (issue_page) begin
                    ptr_next = ptr_reg + fpra_pkg::PTR_W'(1);
                end
                if (chk_vld_reg) begin
                    run_next = map_rdata ? '0 : run_inc;
                end
                if (scan_fit) begin
                    base_next = fpra_pkg::PAGE_W'(base_calc);
                    end_next  = chk_ptr_reg[fpra_pkg::PAGE_W-1:0];
                    ptr_next  = fpra_pkg::PTR_W'(base_calc);
                end else if (scan_last) begin
                    status_next = fpra_pkg::STAT_NO_SPACE;
                end
            end
            fpra_pkg::ST_MARK: begin
                if (mark_last) begin
                    valid_next[slot_reg] = 1'b1;
                    status_next          = fpra_pkg::STAT_OK;
                    run_start_next       = fpra_pkg::RUN_START_W'(base_reg);
                end else begin
                    ptr_next = ptr_reg + fpra_pkg::PTR_W'(1);
                end
            end
            fpra_pkg::ST_LOOK: begin
                // Issue one table read per cycle and compare the one before.
                chk_vld_next   = issue_slot;
                chk_slot_next  = slot_idx;
                chk_valid_next = issue_slot && valid_reg[slot_idx];
                if (issue_slot) begin
                    slot_ptr_next = slot_ptr_reg + fpra_pkg::SCNT_W'(1);
                end
                if (look_hit) begin
                    slot_next  = chk_slot_reg;
                    count_next = tbl_pages;
                    freed_next = fpra_pkg::FREED_W'(tbl_pages);
                    ptr_next   = fpra_pkg::PTR_W'(tbl_start);
                end else if (look_last) begin
                    status_next = fpra_pkg::STAT_NOT_FOUND;
                end
            end
            fpra_pkg::ST_UNMARK: begin
                ptr_next   = ptr_reg + fpra_pkg::PTR_W'(1);
                count_next = count_reg - fpra_pkg::COUNT_W'(1);
                if (unmark_last) begin
                    valid_next[slot_reg] = 1'b0;
                    status_next          = fpra_pkg::STAT_OK;
                end
            end
            fpra_pkg::ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Memory requests and status outputs.
    always_comb begin
        map_req.we    = 1'b0;
        map_req.waddr = ptr_reg[fpra_pkg::PAGE_W-1:0];
        map_req.wdata = 1'b0;
        map_req.raddr = ptr_reg[fpra_pkg::PAGE_W-1:0];
        tbl_req.we    = 1'b0;
        tbl_req.waddr = slot_reg;
        tbl_req.wdata = {base_reg, count_reg};
        tbl_req.raddr = slot_idx;
        case (state_reg)
            fpra_pkg::ST_INIT: begin
                map_req.we = 1'b1;
            end
            fpra_pkg::ST_MARK: begin
                map_req.we    = 1'b1;
                map_req.wdata = 1'b1;
                tbl_req.we    = mark_last;
            end
            fpra_pkg::ST_UNMARK: begin
                map_req.we = issue_page;
            end
            default: begin
            end
        endcase
        idle               = (state_reg == fpra_pkg::ST_IDLE);
        res_valid          = (state_reg == fpra_pkg::ST_DONE);
        result.status      = status_reg;
        result.run_start   = run_start_reg;
        result.freed_pages = freed_reg;
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= fpra_pkg::ST_INIT;
            ptr_reg      <= '0;
            chk_vld_reg  <= 1'b0;
            slot_ptr_reg <= '0;
            valid_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            ptr_reg      <= ptr_next;
            chk_vld_reg  <= chk_vld_next;
            slot_ptr_reg <= slot_ptr_next;
            valid_reg    <= valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        count_reg     <= count_next;
        start_reg     <= start_next;
        chk_ptr_reg   <= chk_ptr_next;
        chk_slot_reg  <= chk_slot_next;
        chk_valid_reg <= chk_valid_next;
        run_reg       <= run_next;
        base_reg      <= base_next;
        end_reg       <= end_next;
        slot_reg      <= slot_next;
        status_reg    <= status_next;
        run_start_reg <= run_start_next;
        freed_reg     <= freed_next;
    end

endmodule

`default_nettype wire

@@ tb/sv/tb_first_fit_page_run_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_page_run_allocator: self-checking bench for the page allocator
// Drives allocate and free transactions through the request channel and checks
// every response against an in-bench model of the page bitmap and the
// allocation table. A short directed part covers the corner cases. Random
// phases at several first_page settings follow, with request gaps and
// response back-pressure.
// ----------------------------------------------------------------------------

import fpra_pkg::*;

// Tracks the bitmap and allocation table and holds the responses still owed.
class alloc_tracker;
    logic [FIRST_W-1:0]   first_page;
    logic [NUM_PAGES-1:0] page_map;
    bit                   slot_used [ALLOC_SLOTS];
    logic [PAGE_W-1:0]    slot_start [ALLOC_SLOTS];
    logic [COUNT_W-1:0]   slot_pages [ALLOC_SLOTS];
    result_t              owed_responses [$];
    int                   errors;

    function new();
        first_page = '0;
        page_map   = '0;
        errors     = 0;
        foreach (slot_used[s]) begin
            slot_used[s]  = 1'b0;
            slot_start[s] = '0;
            slot_pages[s] = '0;
        end
    endfunction

    // Applies one request to the bitmap and table and returns its response.
    function result_t apply_request(cmd_t cmd, logic [COUNT_W-1:0] count,
                                    logic [START_W-1:0] start);
        result_t r;
        int      slot;
        int      run;
        int      base;
        int      p;
        int      q;
        int      s;
        bit      found;

        r.status      = STAT_OK;
        r.run_start   = '0;
        r.freed_pages = '0;
        if (cmd == CMD_ALLOC) begin
            slot = -1;
            for (s = 0; s < ALLOC_SLOTS; s++) begin
                if (!slot_used[s] && slot < 0) begin
                    slot = s;
                end
            end
            if (count == 0) begin
                r.status = STAT_NO_SPACE;
            end else if (slot < 0) begin
                r.status = STAT_TABLE_FULL;
            end else begin
                // First-fit scan upward from the configured start page.
                r.status = STAT_NO_SPACE;
                run = 0;
                for (p = int'(first_page); p < NUM_PAGES && r.status != STAT_OK; p++) begin
                    if (page_map[p]) begin
                        run = 0;
                    end else begin
                        run++;
                        if (run == int'(count)) begin
                            base = p + 1 - run;
                            for (q = base; q <= p; q++) begin
                                page_map[q] = 1'b1;
                            end
                            slot_used[slot]  = 1'b1;
                            slot_start[slot] = PAGE_W'(base);
                            slot_pages[slot] = count;
                            r.status    = STAT_OK;
                            r.run_start = RUN_START_W'(base);
                        end
                    end
                end
            end
        end else begin
            // Free the lowest valid record whose start page matches.
            found = 1'b0;
            for (s = 0; s < ALLOC_SLOTS; s++) begin
                if (!found && slot_used[s] && slot_start[s] == start) begin
                    found = 1'b1;
                    for (q = 0; q < int'(slot_pages[s]); q++) begin
                        if (int'(start) + q < NUM_PAGES) begin
                            page_map[int'(start) + q] = 1'b0;
                        end
                    end
                    r.freed_pages = slot_pages[s];
                    slot_used[s]  = 1'b0;
                end
            end
            if (!found) begin
                r.status = STAT_NOT_FOUND;
            end
        end
        return r;
    endfunction

    function void note_request(cmd_t cmd, logic [COUNT_W-1:0] count,
                               logic [START_W-1:0] start);
        owed_responses.push_back(apply_request(cmd, count, start));
    endfunction

    function int pending();
        return owed_responses.size();
    endfunction

    // Start page of a randomly chosen live allocation, or -1 if none exists.
    function int pick_live_start();
        int live [$];
        int s;

        for (s = 0; s < ALLOC_SLOTS; s++) begin
            if (slot_used[s]) begin
                live.push_back(s);
            end
        end
        if (live.size() == 0) begin
            return -1;
        end
        return int'(slot_start[live[$urandom_range(0, live.size() - 1)]]);
    endfunction

    task report(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    task check_result(logic [1:0] st, logic [RUN_START_W-1:0] rs,
                      logic [FREED_W-1:0] fp);
        result_t want;

        if (owed_responses.size() == 0) begin
            report($sformatf("response with none owed: status %0d", st));
        end else begin
            want = owed_responses.pop_front();
            if (st !== want.status) begin
                report($sformatf("status %0d, expected %s", st, want.status.name()));
            end
            if (rs !== want.run_start) begin
                report($sformatf("run_start %0d, expected %0d", rs, want.run_start));
            end
            if (fp !== want.freed_pages) begin
                report($sformatf("freed_pages %0d, expected %0d", fp, want.freed_pages));
            end
        end
    endtask
endclass

module tb_first_fit_page_run_allocator;

    localparam int          DRAIN_CYCLES = 2 * NUM_PAGES + ALLOC_SLOTS + 64;
    localparam int unsigned CYCLE_LIMIT  = 8_000_000;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_command;
    logic [COUNT_W-1:0]     s_page_count;
    logic [START_W-1:0]     s_start_page;
    logic                   m_valid;
    logic                   m_ready;
    logic [1:0]             m_status;
    logic [RUN_START_W-1:0] m_run_start;
    logic [FREED_W-1:0]     m_freed_pages;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [FIRST_W-1:0]     cfg_data;

    alloc_tracker tracker;
    int           s_idle_pct;
    int           m_stall_pct;
    int unsigned  cycles;

    first_fit_page_run_allocator dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_page_count  (s_page_count),
        .s_start_page  (s_start_page),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_run_start   (m_run_start),
        .m_freed_pages (m_freed_pages),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Watchdog on the total run length.
    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Response back-pressure in random bursts.
    initial begin
        int stall_left;

        stall_left = 0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 99) < m_stall_pct) begin
                stall_left = $urandom_range(0, 6);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Every accepted response is checked against the oldest one owed.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            tracker.check_result(m_status, m_run_start, m_freed_pages);
        end
    end

    // Presents one request, after an optional gap, and waits until it is accepted.
    task send_item(cmd_t cmd, logic [COUNT_W-1:0] count, logic [START_W-1:0] start);
        int gap;

        if ($urandom_range(0, 99) < s_idle_pct) begin
            gap = $urandom_range(1, 7);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_command    <= cmd;
        s_page_count <= count;
        s_start_page <= start;
        do @(posedge aclk); while (!s_ready);
        tracker.note_request(cmd, count, start);
    endtask

    // Waits until the block is idle, then writes the first_page register.
    task set_first_page(logic [FIRST_W-1:0] page);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= page;
        do @(posedge aclk); while (!cfg_ready);
        tracker.first_page = page;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // One random phase: mostly allocations and frees of live runs, with some
    // frees of arbitrary pages and out-of-range sizes mixed in.
    task run_phase(int page, int n_items, int alloc_pct, int idle_pct);
        int                 i;
        int                 live;
        int                 pick;
        cmd_t               cmd;
        logic [COUNT_W-1:0] count;
        logic [START_W-1:0] start;

        set_first_page(FIRST_W'(page));
        s_idle_pct  = idle_pct;
        m_stall_pct = idle_pct;
        for (i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            if (alloc_pct >= 85 && $urandom_range(0, 9) != 0) begin
                count = COUNT_W'($urandom_range(1, 8));
            end else if (pick < 70) begin
                count = COUNT_W'($urandom_range(1, 16));
            end else if (pick < 85) begin
                count = COUNT_W'($urandom_range(17, 128));
            end else if (pick < 93) begin
                count = COUNT_W'($urandom_range(129, NUM_PAGES));
            end else if (pick < 96) begin
                count = COUNT_W'($urandom_range(NUM_PAGES + 1, 2047));
            end else if (pick < 98) begin
                count = '0;
            end else begin
                count = COUNT_W'(NUM_PAGES);
            end
            start = START_W'($urandom_range(0, 1023));
            if ($urandom_range(0, 99) < alloc_pct) begin
                cmd = CMD_ALLOC;
            end else begin
                cmd  = CMD_FREE;
                live = tracker.pick_live_start();
                if (live >= 0 && $urandom_range(0, 9) < 8) begin
                    start = START_W'(live);
                end
            end
            send_item(cmd, count, start);
        end
    endtask

    // Main sequence.
    initial begin
        tracker      = new();
        s_idle_pct   = 0;
        m_stall_pct  = 0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_command    = CMD_ALLOC;
        s_page_count = '0;
        s_start_page = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: whole heap, oversize and zero requests, first fit into holes.
        set_first_page('0);
        s_idle_pct  = 30;
        m_stall_pct = 30;
        send_item(CMD_ALLOC, 11'd1024, 10'd0);
        send_item(CMD_ALLOC, 11'd1, 10'd0);
        send_item(CMD_FREE, 11'd0, 10'd0);
        send_item(CMD_FREE, 11'd0, 10'd0);
        send_item(CMD_ALLOC, 11'd0, 10'd1023);
        send_item(CMD_ALLOC, 11'd2047, 10'd0);
        send_item(CMD_ALLOC, 11'd1025, 10'd0);
        send_item(CMD_ALLOC, 11'd1, 10'd0);
        send_item(CMD_ALLOC, 11'd3, 10'd0);
        send_item(CMD_FREE, 11'd2047, 10'd0);
        send_item(CMD_ALLOC, 11'd2, 10'd0);
        send_item(CMD_ALLOC, 11'd1, 10'd0);
        send_item(CMD_FREE, 11'd0, 10'd1023);
        send_item(CMD_FREE, 11'd0, 10'd1);
        send_item(CMD_FREE, 11'd0, 10'd4);
        send_item(CMD_FREE, 11'd0, 10'd0);

        // Directed: scan starting at the top page only.
        set_first_page(10'd1023);
        send_item(CMD_ALLOC, 11'd1, 10'd0);
        send_item(CMD_ALLOC, 11'd1, 10'd0);
        send_item(CMD_ALLOC, 11'd2, 10'd0);
        send_item(CMD_FREE, 11'd0, 10'd1023);

        // Random phases; the first one fills the allocation table.
        run_phase(0, 100, 90, 30);
        run_phase($urandom_range(1, 1022), 80, 50, 50);
        run_phase(1023, 20, 60, 20);
        run_phase(0, 100, 45, 15);
        run_phase($urandom_range(0, 300), 100, 85, 40);
        run_phase($urandom_range(512, 1000), 80, 50, 25);
        run_phase(0, 100, 55, 0);

        // Drain, then allow time for any stray response to show up.
        @(negedge aclk);
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tracker.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/fpra_pkg.sv
hw/rtl/fpra_ram.sv
hw/rtl/fpra_seq.sv
hw/rtl/first_fit_page_run_allocator.sv
tb/sv/tb_first_fit_page_run_allocator.sv
